### sv/s256_pkg.sv
// Shared types, constants and functions of the SHA-256 stream hasher.
package s256_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned CountW    = 61;

  // Entry kinds in the word queue
  typedef enum logic {
    KIND_DATA  = 1'b0,
    KIND_FINAL = 1'b1
  } kind_e;

  // One queue entry: a packed word, or the end of a message with its tail
  typedef struct packed {
    kind_e              kind;
    logic [31:0]        data;
    logic [2:0]         nbytes;  // bytes held in data, 0 to 4, final entries only
    logic [CountW-1:0]  len;     // message length in bytes, final entries only
  } q_entry_t;

  typedef logic [31:0] word_t;

  function automatic word_t iv_word(input logic [2:0] idx);
    word_t r;
    unique case (idx)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic word_t round_k(input logic [5:0] idx);
    word_t r;
    unique case (idx)
      6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491; 6'd2:  r = 32'hb5c0fbcf;
      6'd3:  r = 32'he9b5dba5; 6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5; 6'd8:  r = 32'hd807aa98;
      6'd9:  r = 32'h12835b01; 6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sig0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sig1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sig0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sig1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

### sv/s256_front.sv
// Front end: packs incoming bytes into big-endian words and counts the message.
module s256_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_byte_i,
  input  logic               in_present_i,
  input  logic               in_end_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output s256_pkg::q_entry_t q_entry_o
);

  logic [31:0]                 word_q, word_d;
  logic [2:0]                  bpos_q, bpos_n;
  logic [s256_pkg::CountW-1:0] count_q, count_n;
  logic                        take;

  assign in_ready_o = !q_full_i;
  assign take       = in_valid_i && in_ready_o;

  // Place the byte; the first byte of a word overwrites the whole word
  always_comb begin
    word_d  = word_q;
    bpos_n  = bpos_q;
    count_n = count_q;
    if (in_present_i) begin
      if (bpos_q == 3'd0) begin
        word_d = {in_byte_i, 24'h0};
      end else begin
        word_d = word_q | ({24'h0, in_byte_i} << (5'd24 - {bpos_q[1:0], 3'b000}));
      end
      bpos_n  = bpos_q + 3'd1;
      count_n = count_q + 1'b1;
    end
  end

  // Push full words, and the tail with the length at end of message
  always_comb begin
    q_push_o         = take && (in_end_i || (in_present_i && bpos_n == 3'd4));
    q_entry_o.kind   = in_end_i ? s256_pkg::KIND_FINAL : s256_pkg::KIND_DATA;
    q_entry_o.data   = word_d;
    q_entry_o.nbytes = bpos_n;
    q_entry_o.len    = count_n;
  end

  // Hold position and count; clear both at end of message
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpos_q  <= 3'd0;
      count_q <= '0;
    end else if (take) begin
      if (in_end_i) begin
        bpos_q  <= 3'd0;
        count_q <= '0;
      end else begin
        bpos_q  <= (bpos_n == 3'd4) ? 3'd0 : bpos_n;
        count_q <= count_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      word_q <= word_d;
    end
  end

endmodule

### sv/s256_fifo.sv
// Short word queue between front end and compression engine.
module s256_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  s256_pkg::q_entry_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output s256_pkg::q_entry_t pop_data_o
);

  s256_pkg::q_entry_t          mem_q [s256_pkg::FifoDepth];
  logic [s256_pkg::FifoAw-1:0] wr_q, rd_q;
  logic [s256_pkg::FifoAw:0]   cnt_q;
  logic                        do_push, do_pop;

  assign full_o     = (cnt_q == (s256_pkg::FifoAw + 1)'(s256_pkg::FifoDepth));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_q];

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

### sv/s256_back.sv
// Back end: block assembly, padding, 64-round compression and digest output.
module s256_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  output logic               q_pop_o,
  input  s256_pkg::q_entry_t q_entry_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        out_word_o,
  output logic [2:0]         out_index_o,
  output logic               out_last_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_LEN, S_COMP, S_ADD, S_OUT
  } state_e;

  // What follows a compression
  typedef enum logic [1:0] {
    PH_DATA, PH_PAD_PEND, PH_LAST1, PH_FINAL
  } phase_e;

  state_e                      st_q;
  phase_e                      ph_q;
  logic [31:0]                 blk_q [16];
  logic [31:0]                 hv_q  [8];
  logic [31:0]                 var_q [8];
  logic [3:0]                  wc_q;
  logic [5:0]                  rnd_q;
  logic [2:0]                  oidx_q;
  logic [1:0]                  nb_q;
  logic [s256_pkg::CountW-1:0] len_q;
  logic [63:0]                 bits;
  logic [31:0]                 pad_word, t1, t2, w_new;
  logic                        out_done;

  assign q_pop_o     = (st_q == S_IDLE) && !q_empty_i;
  assign out_valid_o = (st_q == S_OUT);
  assign out_word_o  = hv_q[oidx_q];
  assign out_index_o = oidx_q;
  assign out_last_o  = (oidx_q == 3'd7);
  assign out_done    = out_valid_o && out_ready_i && out_last_o;
  assign bits        = {len_q, 3'b000};

  // Append the end marker behind the tail bytes
  always_comb begin
    if (nb_q == 2'd0) begin
      pad_word = 32'h8000_0000;
    end else begin
      pad_word = blk_q[wc_q] | (32'h0000_0080 << (5'd24 - {nb_q, 3'b000}));
    end
  end

  // One round and one schedule word
  always_comb begin
    t1 = var_q[7] + s256_pkg::big_sig1(var_q[4])
       + ((var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]))
       + s256_pkg::round_k(rnd_q) + blk_q[0];
    t2 = s256_pkg::big_sig0(var_q[0])
       + ((var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]));
    w_new = s256_pkg::small_sig1(blk_q[14]) + blk_q[9]
          + s256_pkg::small_sig0(blk_q[1]) + blk_q[0];
  end

  // Sequence block loads, compressions and digest output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      ph_q   <= PH_DATA;
      wc_q   <= 4'd0;
      rnd_q  <= 6'd0;
      oidx_q <= 3'd0;
      for (int i = 0; i < 8; i++) begin
        hv_q[i] <= s256_pkg::iv_word(3'(i));
      end
    end else begin
      unique case (st_q)
        S_IDLE: begin
          if (q_pop_o) begin
            if (q_entry_i.kind == s256_pkg::KIND_DATA || q_entry_i.nbytes == 3'd4) begin
              if (wc_q == 4'd15) begin
                wc_q <= 4'd0;
                ph_q <= (q_entry_i.kind == s256_pkg::KIND_DATA) ? PH_DATA : PH_PAD_PEND;
                st_q <= S_COMP;
                for (int i = 0; i < 8; i++) begin
                  var_q[i] <= hv_q[i];
                end
              end else begin
                wc_q <= wc_q + 4'd1;
                if (q_entry_i.kind == s256_pkg::KIND_FINAL) begin
                  st_q <= S_PAD;
                end
              end
            end else begin
              st_q <= S_PAD;
            end
          end
        end
        S_PAD: begin
          ph_q <= (wc_q >= 4'd14) ? PH_LAST1 : PH_FINAL;
          wc_q <= 4'd0;
          st_q <= S_COMP;
          for (int i = 0; i < 8; i++) begin
            var_q[i] <= hv_q[i];
          end
        end
        S_LEN: begin
          ph_q <= PH_FINAL;
          st_q <= S_COMP;
          for (int i = 0; i < 8; i++) begin
            var_q[i] <= hv_q[i];
          end
        end
        S_COMP: begin
          var_q[0] <= t1 + t2;
          var_q[1] <= var_q[0];
          var_q[2] <= var_q[1];
          var_q[3] <= var_q[2];
          var_q[4] <= var_q[3] + t1;
          var_q[5] <= var_q[4];
          var_q[6] <= var_q[5];
          var_q[7] <= var_q[6];
          rnd_q    <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) begin
            st_q <= S_ADD;
          end
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) begin
            hv_q[i] <= hv_q[i] + var_q[i];
          end
          unique case (ph_q)
            PH_DATA:     st_q <= S_IDLE;
            PH_PAD_PEND: st_q <= S_PAD;
            PH_LAST1:    st_q <= S_LEN;
            default:     st_q <= S_OUT;
          endcase
        end
        S_OUT: begin
          if (out_ready_i) begin
            oidx_q <= oidx_q + 3'd1;
            if (out_last_o) begin
              st_q <= S_IDLE;
              for (int i = 0; i < 8; i++) begin
                hv_q[i] <= s256_pkg::iv_word(3'(i));
              end
            end
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // Block buffer: load words, pad, and shift the schedule during rounds
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      S_IDLE: begin
        if (q_pop_o) begin
          blk_q[wc_q] <= q_entry_i.data;
          nb_q        <= q_entry_i.nbytes[1:0];
          len_q       <= q_entry_i.len;
        end
      end
      S_PAD: begin
        // Clear behind the marker; write the length words when they fit
        for (int i = 0; i < 16; i++) begin
          if (4'(i) == wc_q) begin
            blk_q[i] <= pad_word;
          end else if (4'(i) > wc_q && (i < 14 || wc_q >= 4'd14)) begin
            blk_q[i] <= 32'h0;
          end
        end
        if (wc_q < 4'd14) begin
          blk_q[14] <= bits[63:32];
          blk_q[15] <= bits[31:0];
        end
      end
      S_LEN: begin
        for (int i = 0; i < 14; i++) begin
          blk_q[i] <= 32'h0;
        end
        blk_q[14] <= bits[63:32];
        blk_q[15] <= bits[31:0];
      end
      S_COMP: begin
        for (int i = 0; i < 15; i++) begin
          blk_q[i] <= blk_q[i+1];
        end
        blk_q[15] <= w_new;
      end
      default: ;
    endcase
  end

  a_round_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_COMP && rnd_q == 6'd63) |=> (st_q == S_ADD && rnd_q == 6'd0))
    else $error("compression did not end after 64 rounds");

  a_digest_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_done |=> (st_q == S_IDLE && wc_q == 4'd0 && oidx_q == 3'd0
                  && hv_q[0] == 32'h6a09e667))
    else $error("state not restored after digest");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_COMP || st_q == S_OUT) |-> !q_pop_o)
    else $error("queue popped while engine busy");

endmodule

### sv/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher: front end, word queue, engine.
//
//  channel  dir  tdata              tuser          tlast
//  s_axis   in   data_byte[7:0]     byte_present   end_of_message
//  m_axis   out  digest_word[31:0]  word_index     last_word
//
// Bytes are taken one per cycle while the four-entry word queue has room.
// Each data block costs 16 word loads, 64 rounds and an add step in the
// engine; padding adds one or two blocks of a setup step, 64 rounds and
// an add, then eight words.
// Reset restores the initial hash values and empties the queue.
// A stalled output holds the engine; the front keeps filling the queue.
module sha256_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] byte_present
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser_o,   // [2:0] word_index
  output logic        m_axis_tlast_o
);

  s256_pkg::q_entry_t push_entry, pop_entry;
  logic               q_push, q_full, q_pop, q_empty;

  s256_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_byte_i    (s_axis_tdata_i),
    .in_present_i (s_axis_tuser_i),
    .in_end_i     (s_axis_tlast_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_entry_o    (push_entry)
  );

  s256_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_entry),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (pop_entry)
  );

  s256_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .q_entry_i   (pop_entry),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_word_o  (m_axis_tdata_o),
    .out_index_o (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule
